/* rtl/core/tztl_pkg.sv */
// Shared constants, types and datapath command codes for the time zone lookup core.
package tztl_pkg;

  localparam int MAX_TYPES       = 256;
  localparam int MAX_TRANSITIONS = 1024;

  localparam int TY_AW  = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int TR_AW  = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int TYC_W  = $clog2(MAX_TYPES + 1);
  localparam int TRC_W  = $clog2(MAX_TRANSITIONS + 1);

  localparam int FUNC_W = 3;
  localparam int TIME_W = 63;
  localparam int OFF_W  = 18;
  localparam int IDX_W  = 8;
  localparam int CONV_W = 64;
  localparam int STAT_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_UTC    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOCAL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_TYPE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD     = 2'd3;

  localparam logic signed [OFF_W-1:0] OFF_MIN = -18'sd100000;
  localparam logic signed [OFF_W-1:0] OFF_MAX = 18'sd100000;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_LOAD,
    OP_APP_RD,
    OP_APP_WR,
    OP_CLEAR,
    OP_BAD,
    OP_NOTYPE,
    OP_PROBE,
    OP_STEP,
    OP_RD_A,
    OP_RD_I,
    OP_SAVE_I,
    OP_SAVE_P,
    OP_CMP1,
    OP_SAVE_PP,
    OP_CMP2,
    OP_K_TRANS,
    OP_K_ZERO,
    OP_RD_K,
    OP_FIN,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              no_types;
    logic              search_done;
    logic              lo_zero;
    logic              lo_at_end;
    logic              cmp_done;
  } dp_stat_t;

  typedef struct packed {
    logic signed [CONV_W-1:0] utc;
    logic signed [CONV_W-1:0] lcl;
    logic [IDX_W-1:0]         ty;
  } trans_ent_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] off;
    logic                    dst;
    logic [IDX_W-1:0]        abb;
  } type_ent_t;

endpackage

/* rtl/core/tztl_datapath.sv */
// Datapath: type and transition memories, counts, search bounds and result registers.
module tztl_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  tztl_pkg::dp_cmd_t                cmd,
  output tztl_pkg::dp_stat_t               stat,
  input  logic [tztl_pkg::FUNC_W-1:0]      func,
  input  logic signed [tztl_pkg::TIME_W-1:0] time_value,
  input  logic signed [tztl_pkg::OFF_W-1:0]  utc_offset,
  input  logic                             is_dst,
  input  logic [tztl_pkg::IDX_W-1:0]       abbrev_index,
  input  logic [tztl_pkg::IDX_W-1:0]       type_index,
  input  logic                             post_transition,
  output logic signed [tztl_pkg::OFF_W-1:0]  offset_out,
  output logic                             dst_out,
  output logic [tztl_pkg::IDX_W-1:0]       abbrev_out,
  output logic signed [tztl_pkg::CONV_W-1:0] converted_time,
  output logic [tztl_pkg::STAT_W-1:0]      status
);
  import tztl_pkg::*;

  trans_ent_t tr_mem [MAX_TRANSITIONS];
  type_ent_t  ty_mem [MAX_TYPES];
  trans_ent_t tr_rdata;
  type_ent_t  ty_rdata;

  logic [FUNC_W-1:0]        func_r;
  logic signed [TIME_W-1:0] tv_r;
  logic signed [OFF_W-1:0]  off_r;
  logic                     dst_r;
  logic [IDX_W-1:0]         abb_r;
  logic [IDX_W-1:0]         ti_r;
  logic                     post_r;
  logic [TYC_W-1:0]         type_count;
  logic [TRC_W-1:0]         trans_count;
  logic [TRC_W-1:0]         lo;
  logic [TRC_W-1:0]         hi;
  logic [TRC_W-1:0]         mid;
  logic signed [CONV_W-1:0] utc_i;
  logic signed [CONV_W-1:0] utc_p;
  logic [IDX_W-1:0]         type_i;
  logic [IDX_W-1:0]         type_p;
  logic [IDX_W-1:0]         type_pp;
  logic [IDX_W-1:0]         k;
  logic                     cmp_done;
  logic signed [OFF_W-1:0]  res_off;
  logic                     res_dst;
  logic [IDX_W-1:0]         res_abb;
  logic signed [CONV_W-1:0] res_conv;
  logic [STAT_W-1:0]        res_status;

  logic                     tr_re;
  logic [TR_AW-1:0]         tr_raddr;
  logic                     ty_re;
  logic [TY_AW-1:0]         ty_raddr;
  logic                     tr_we;
  logic                     ty_we;
  logic [TRC_W:0]           mid_sum;
  logic [TRC_W-1:0]         mid_c;
  logic [TRC_W-1:0]         lo_m1;
  logic [TRC_W-1:0]         lo_m2;
  logic [TRC_W-1:0]         tc_m1;
  logic signed [CONV_W-1:0] tv64;
  logic signed [CONV_W-1:0] off64;
  logic signed [CONV_W-1:0] loc;
  logic signed [CONV_W-1:0] prior_sec;
  logic signed [CONV_W-1:0] key;
  logic                     load_full;
  logic                     load_range;
  logic                     app_badtype;
  logic                     app_full;
  logic                     app_order;

  always_comb begin
    mid_sum   = {1'b0, lo} + {1'b0, hi};
    mid_c     = mid_sum[TRC_W:1];
    lo_m1     = lo - TRC_W'(1);
    lo_m2     = lo - TRC_W'(2);
    tc_m1     = trans_count - TRC_W'(1);
    tv64      = {tv_r[TIME_W-1], tv_r};
    off64     = {{(CONV_W-OFF_W){ty_rdata.off[OFF_W-1]}}, ty_rdata.off};
    loc       = tv64 + off64;
    key       = (func_r == FUNC_UTC) ? tr_rdata.utc : tr_rdata.lcl;
    prior_sec = ((cmd.op == OP_CMP1) ? utc_i : utc_p) - CONV_W'(1) + off64;
    load_full   = (32'(type_count) >= MAX_TYPES);
    load_range  = (off_r < OFF_MIN) || (off_r > OFF_MAX);
    app_badtype = (32'(ti_r) >= 32'(type_count));
    app_full    = (32'(trans_count) >= MAX_TRANSITIONS);
    app_order   = (trans_count != '0) && ((tv64 < tr_rdata.utc) || (loc < tr_rdata.lcl));
    tr_re    = 1'b0;
    tr_raddr = '0;
    ty_re    = 1'b0;
    ty_raddr = '0;
    unique case (cmd.op)
      OP_APP_RD: begin
        tr_re    = 1'b1;
        tr_raddr = tc_m1[TR_AW-1:0];
        ty_re    = 1'b1;
        ty_raddr = TY_AW'(ti_r);
      end
      OP_PROBE: begin
        tr_re    = 1'b1;
        tr_raddr = mid_c[TR_AW-1:0];
      end
      OP_RD_A, OP_SAVE_I: begin
        tr_re    = 1'b1;
        tr_raddr = lo_m1[TR_AW-1:0];
      end
      OP_RD_I: begin
        tr_re    = 1'b1;
        tr_raddr = lo[TR_AW-1:0];
      end
      OP_CMP1: begin
        tr_re    = 1'b1;
        tr_raddr = lo_m2[TR_AW-1:0];
      end
      OP_SAVE_P, OP_SAVE_PP, OP_K_TRANS: begin
        ty_re    = 1'b1;
        ty_raddr = TY_AW'(tr_rdata.ty);
      end
      OP_K_ZERO: begin
        ty_re    = 1'b1;
        ty_raddr = '0;
      end
      OP_RD_K: begin
        ty_re    = 1'b1;
        ty_raddr = TY_AW'(k);
      end
      default: begin
      end
    endcase
    ty_we = (cmd.op == OP_LOAD) && !load_full && !load_range;
    tr_we = (cmd.op == OP_APP_WR) && !app_badtype && !app_full && !app_order;
  end

  always_ff @(posedge clk) begin
    if (tr_re) begin
      tr_rdata <= tr_mem[tr_raddr];
    end
    if (tr_we) begin
      tr_mem[trans_count[TR_AW-1:0]] <= '{utc: tv64, lcl: loc, ty: ti_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ty_re) begin
      ty_rdata <= ty_mem[ty_raddr];
    end
    if (ty_we) begin
      ty_mem[type_count[TY_AW-1:0]] <= '{off: off_r, dst: dst_r, abb: abb_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      type_count  <= '0;
      trans_count <= '0;
    end else begin
      if (ty_we) type_count <= type_count + TYC_W'(1);
      if (tr_we) trans_count <= trans_count + TRC_W'(1);
      if (cmd.op == OP_CLEAR) begin
        type_count  <= '0;
        trans_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_START: begin
        func_r   <= func;
        tv_r     <= time_value;
        off_r    <= utc_offset;
        dst_r    <= is_dst;
        abb_r    <= abbrev_index;
        ti_r     <= type_index;
        post_r   <= post_transition;
        lo       <= '0;
        hi       <= trans_count;
        res_off  <= '0;
        res_dst  <= 1'b0;
        res_abb  <= '0;
        res_conv <= '0;
      end
      OP_LOAD: begin
        res_status <= load_full ? ST_FULL : (load_range ? ST_BAD : ST_OK);
      end
      OP_APP_WR: begin
        priority if (app_badtype) res_status <= ST_BAD;
        else if (app_full) res_status <= ST_FULL;
        else if (app_order) res_status <= ST_BAD;
        else res_status <= ST_OK;
      end
      OP_CLEAR:  res_status <= ST_OK;
      OP_BAD:    res_status <= ST_BAD;
      OP_NOTYPE: begin
        res_status <= ST_NO_TYPE;
        res_conv   <= tv64;
      end
      OP_PROBE: mid <= mid_c;
      OP_STEP: begin
        if (key > tv64) hi <= mid;
        else lo <= mid + TRC_W'(1);
      end
      OP_SAVE_I: begin
        utc_i  <= tr_rdata.utc;
        type_i <= tr_rdata.ty;
      end
      OP_SAVE_P: begin
        utc_p  <= tr_rdata.utc;
        type_p <= tr_rdata.ty;
      end
      OP_CMP1: begin
        // later side of a skipped span, or nothing earlier to compare with
        if (prior_sec < tv64) begin
          k        <= post_r ? type_i : type_p;
          cmp_done <= 1'b1;
        end else if (lo == TRC_W'(1)) begin
          k        <= type_p;
          cmp_done <= 1'b1;
        end else begin
          cmp_done <= 1'b0;
        end
      end
      OP_SAVE_PP: type_pp <= tr_rdata.ty;
      OP_CMP2: begin
        if (tv64 <= prior_sec) k <= post_r ? type_p : type_pp;
        else k <= type_p;
      end
      OP_FIN: begin
        res_off    <= ty_rdata.off;
        res_dst    <= ty_rdata.dst;
        res_abb    <= ty_rdata.abb;
        res_conv   <= (func_r == FUNC_UTC) ? (tv64 + off64) : (tv64 - off64);
        res_status <= ST_OK;
      end
      OP_PUBLISH: begin
        offset_out     <= res_off;
        dst_out        <= res_dst;
        abbrev_out     <= res_abb;
        converted_time <= res_conv;
        status         <= res_status;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.func        = func_r;
    stat.no_types    = (type_count == '0);
    stat.search_done = (lo == hi);
    stat.lo_zero     = (lo == '0);
    stat.lo_at_end   = (lo == trans_count);
    stat.cmp_done    = cmp_done;
  end

endmodule

/* rtl/core/tztl_ctrl.sv */
// Controller: sequences one item through the datapath and runs the handshakes.
module tztl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tztl_pkg::dp_stat_t  stat,
  output tztl_pkg::dp_cmd_t   cmd
);
  import tztl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_APP_WR,
    S_PROBE,
    S_STEP,
    S_UTC_K,
    S_L_SAVEI,
    S_L_SAVEP,
    S_L_CMP1,
    S_L_CHK,
    S_L_CMP2,
    S_RDK,
    S_FIN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   is_utc;

  assign in_ready = (state == S_IDLE);
  assign is_utc   = (stat.func == FUNC_UTC);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_START;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_DONE;
        priority if (stat.func == FUNC_LOAD) cmd.op = OP_LOAD;
        else if (stat.func == FUNC_APPEND) begin
          cmd.op     = OP_APP_RD;
          state_next = S_APP_WR;
        end else if (stat.func == FUNC_UTC || stat.func == FUNC_LOCAL) begin
          if (stat.no_types) cmd.op = OP_NOTYPE;
          else state_next = S_PROBE;
        end else if (stat.func == FUNC_CLEAR) cmd.op = OP_CLEAR;
        else cmd.op = OP_BAD;
      end
      S_APP_WR: begin
        cmd.op     = OP_APP_WR;
        state_next = S_DONE;
      end
      S_PROBE: begin
        priority if (!stat.search_done) begin
          cmd.op     = OP_PROBE;
          state_next = S_STEP;
        end else if (stat.lo_zero) begin
          cmd.op     = OP_K_ZERO;
          state_next = S_FIN;
        end else if (is_utc || stat.lo_at_end) begin
          cmd.op     = OP_RD_A;
          state_next = S_UTC_K;
        end else begin
          cmd.op     = OP_RD_I;
          state_next = S_L_SAVEI;
        end
      end
      S_STEP: begin
        cmd.op     = OP_STEP;
        state_next = S_PROBE;
      end
      S_UTC_K: begin
        cmd.op     = OP_K_TRANS;
        state_next = S_FIN;
      end
      S_L_SAVEI: begin
        cmd.op     = OP_SAVE_I;
        state_next = S_L_SAVEP;
      end
      S_L_SAVEP: begin
        cmd.op     = OP_SAVE_P;
        state_next = S_L_CMP1;
      end
      S_L_CMP1: begin
        cmd.op     = OP_CMP1;
        state_next = S_L_CHK;
      end
      S_L_CHK: begin
        if (stat.cmp_done) begin
          cmd.op     = OP_RD_K;
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_SAVE_PP;
          state_next = S_L_CMP2;
        end
      end
      S_L_CMP2: begin
        cmd.op     = OP_CMP2;
        state_next = S_RDK;
      end
      S_RDK: begin
        cmd.op     = OP_RD_K;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op     = OP_FIN;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid || out_ready) begin
          cmd.op     = OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_PUBLISH) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/time_zone_transition_lookup_core.sv */
// Time zone transition lookup: load types, append transitions, convert UTC and local seconds.
// One item at a time. Load, clear and bad codes are dispatched and then published; append
// first reads the last transition and the named type, then writes. A query binary-searches the
// transition list; each probe is a registered read of the transition memory, then a compare.
// Local time adds neighbor reads and type-offset reads. A result that is not taken holds the
// controller until the output register frees up. The next item is taken once the result sits
// in the output register.
// The tables have no clearing pass: clear only resets the counts.
module time_zone_transition_lookup_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tztl_pkg::FUNC_W-1:0]          func,
  input  logic signed [tztl_pkg::TIME_W-1:0]   time_value,
  input  logic signed [tztl_pkg::OFF_W-1:0]    utc_offset,
  input  logic                                 is_dst,
  input  logic [tztl_pkg::IDX_W-1:0]           abbrev_index,
  input  logic [tztl_pkg::IDX_W-1:0]           type_index,
  input  logic                                 post_transition,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tztl_pkg::OFF_W-1:0]    offset_out,
  output logic                                 dst_out,
  output logic [tztl_pkg::IDX_W-1:0]           abbrev_out,
  output logic signed [tztl_pkg::CONV_W-1:0]   converted_time,
  output logic [tztl_pkg::STAT_W-1:0]          status
);
  import tztl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tztl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tztl_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .func            (func),
    .time_value      (time_value),
    .utc_offset      (utc_offset),
    .is_dst          (is_dst),
    .abbrev_index    (abbrev_index),
    .type_index      (type_index),
    .post_transition (post_transition),
    .offset_out      (offset_out),
    .dst_out         (dst_out),
    .abbrev_out      (abbrev_out),
    .converted_time  (converted_time),
    .status          (status)
  );

  a_publish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_PUBLISH |=> out_valid)
    else $error("published result not shown as valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_PUBLISH |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_start_on_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_START) == (in_valid && in_ready))
    else $error("item capture out of step with acceptance");

endmodule
